@@ src/positional_insert_delete_array_macros.svh @@
// Assertion macros shared by the positional insert/delete array RTL.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`ifndef ASSERT_OFF
// Check cons in the same cycle whenever ante holds.
`define PIDA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pida assertion failed");
// Check cons in the cycle after ante holds.
`define PIDA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pida assertion failed");
`else
`define PIDA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PIDA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/pida_pkg.sv @@
// Shared types and constants of the positional insert/delete array.
package pida_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_DELETE,
      CMD_DUMP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  item_value;
   } cmd_type;

endpackage

@@ src/pida_ifs.sv @@
// Request and response channel interfaces of the positional insert/delete array.
interface pida_req_if import pida_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic [POS_W-1:0]          position;
   logic signed [DATA_W-1:0]  item_value;

   modport source (output valid, output op, output position, output item_value,
                   input ready);
   modport sink   (input valid, input op, input position, input item_value,
                   output ready);
endinterface

interface pida_rsp_if import pida_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [DATA_W-1:0]  result_value;
   logic [COUNT_W-1:0]        entry_count;
   logic                      last;

   modport source (output valid, output status, output result_value,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input result_value,
                   input entry_count, input last, output ready);
endinterface

@@ src/pida_front.sv @@
// Front end: accept requests, decode the op code, drop unused codes.
module pida_front import pida_pkg::*; (
   pida_req_if.sink  req,
   output logic      push_valid,
   output cmd_type   push_cmd,
   input  logic      push_ready
);

   logic known_op;

   always_comb begin
      known_op            = 1'b1;
      push_cmd.position   = req.position;
      push_cmd.item_value = req.item_value;
      unique case (req.op)
         OP_INSERT: push_cmd.kind = CMD_INSERT;
         OP_DELETE: push_cmd.kind = CMD_DELETE;
         OP_DUMP:   push_cmd.kind = CMD_DUMP;
         default: begin
            push_cmd.kind = CMD_INSERT;
            known_op      = 1'b0;
         end
      endcase
   end

   // unused op codes are taken and dropped
   assign req.ready  = push_ready;
   assign push_valid = req.valid && known_op;

endmodule

@@ src/pida_queue.sv @@
// Short command queue between the front end and the array engine.
`include "positional_insert_delete_array_macros.svh"
module pida_queue import pida_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    pop_valid,
   output cmd_type pop_cmd,
   input  logic    pop_ready
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;
   logic                q_stall;

   assign push_ready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign q_stall    = pop_valid && !pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `PIDA_ASSERT_IMP(a_q_bound, clock, reset, 1'b1, cnt_ff <= QCNT_W'(QUEUE_DEPTH))
   `PIDA_ASSERT_NXT(a_q_head_hold, clock, reset, q_stall, pop_valid && pop_cmd == $past(pop_cmd))
   `PIDA_ASSERT_NXT(a_q_fill, clock, reset, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 1'b1)

endmodule

@@ src/pida_back.sv @@
// Array engine: shift register array, position checks, dump walk, response register.
`include "positional_insert_delete_array_macros.svh"
module pida_back import pida_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_ready,
   pida_rsp_if.source rsp
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         dump_idx_ff, dump_idx_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_last_ff, rsp_last_in;

   logic [CMP_W-1:0]         pos_ext, cnt_ext;
   logic [IDX_W-1:0]         rd_idx;
   logic signed [DATA_W-1:0] rd_data;
   logic fire, ins_bad, ins_full, del_bad, dump_empty, dump_last;
   logic ins_go, del_go, dump_go;

   assign fire       = q_valid && (!rsp_valid_ff || rsp.ready);
   assign pos_ext    = CMP_W'(q_cmd.position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign ins_bad    = (pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1));
   assign ins_full   = (cnt_ext >= DEPTH_C);
   assign del_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
   assign dump_empty = (count_ff == '0);
   assign dump_last  = (CMP_W'(dump_idx_ff) + CMP_W'(1)) == cnt_ext;
   assign ins_go     = fire && (q_cmd.kind == CMD_INSERT) && !ins_bad && !ins_full;
   assign del_go     = fire && (q_cmd.kind == CMD_DELETE) && !del_bad;
   assign dump_go    = fire && (q_cmd.kind == CMD_DUMP) && !dump_empty;

   // a dump holds the queue head until its final entry goes out
   assign q_ready = fire && ((q_cmd.kind != CMD_DUMP) || dump_empty || dump_last);

   // single read port, shared by delete and dump
   assign rd_idx  = (q_cmd.kind == CMD_DUMP) ? dump_idx_ff[IDX_W-1:0]
                                             : IDX_W'(pos_ext - CMP_W'(1));
   assign rd_data = entries_ff[rd_idx];

   always_comb begin
      entries_in = entries_ff;
      for (int i = 0; i < DEPTH; i++) begin
         if (ins_go) begin
            if (CMP_W'(i + 1) == pos_ext) begin
               entries_in[i] = q_cmd.item_value;
            end else if ((CMP_W'(i + 1) > pos_ext) && (i > 0)) begin
               entries_in[i] = entries_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (del_go) begin
            if ((CMP_W'(i + 1) >= pos_ext) && (i < DEPTH - 1)) begin
               entries_in[i] = entries_ff[(i < DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_go) begin
         count_in = count_ff + 1'b1;
      end else if (del_go) begin
         count_in = count_ff - 1'b1;
      end
      dump_idx_in = dump_idx_ff;
      if (dump_go) begin
         dump_idx_in = dump_last ? '0 : dump_idx_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_status_in = STATUS_OK;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b1;
      unique case (q_cmd.kind)
         CMD_INSERT: begin
            if (ins_bad) begin
               rsp_status_in = STATUS_BAD_POS;
            end else if (ins_full) begin
               rsp_status_in = STATUS_FULL;
            end
         end
         CMD_DELETE: begin
            if (del_bad) begin
               rsp_status_in = STATUS_BAD_POS;
            end else begin
               rsp_value_in = rd_data;
            end
         end
         CMD_DUMP: begin
            if (dump_empty) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rsp_value_in = rd_data;
               rsp_last_in  = dump_last;
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      rsp_valid_in = fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_count_ff  <= COUNT_W'(count_in);
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.entry_count  = rsp_count_ff;
   assign rsp.last         = rsp_last_ff;

   `PIDA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, CMP_W'(count_ff) <= DEPTH_C)
   `PIDA_ASSERT_IMP(a_dump_idx, clock, reset, dump_idx_ff != '0, dump_idx_ff < count_ff)
   `PIDA_ASSERT_NXT(a_ins_count, clock, reset, ins_go, count_ff == $past(count_ff) + 1'b1)

endmodule

@@ src/positional_insert_delete_array.sv @@
// A request's first response passes through the command queue slot, then the engine's response register.
// Insert and delete each give a single response; a dump returns one stored entry per cycle while
// responses are taken (one response when empty), limited by the single read port of the entry array.
// The two-entry command queue lets requests keep arriving while a dump or a stalled response holds.
// Reset (synchronous, active high) clears the count, queue and response valid; entries stay as is.
module positional_insert_delete_array import pida_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   pida_req_if.sink   req_bus,
   pida_rsp_if.source rsp_bus
);

   // front end to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // queue to engine
   logic    q_valid;
   logic    q_ready;
   cmd_type q_cmd;

   // Decode the op code of each request; unused codes are accepted and dropped here,
   // so they never reach the engine and produce no response.
   pida_front u_front (
      .req        (req_bus),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Hold decoded commands so the front end keeps taking requests while the engine
   // walks a dump or waits on a stalled response.
   pida_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop_ready  (q_ready)
   );

   // Check positions against the live count, shift the entry registers up or down
   // all at once, and drive the response register. Every entry register picks
   // hold, a neighbor, or the new value.
   pida_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_ready (q_ready),
      .rsp     (rsp_bus)
   );

endmodule

@@ test/positional_insert_delete_array_test.sv @@
// Self-checking testbench for the positional insert/delete array, with a shadow array scoreboard.
module positional_insert_delete_array_test import pida_pkg::*; ();

   localparam int ARRAY_DEPTH    = 32;
   localparam int RANDOM_TARGET  = 350;
   localparam int TAIL_START     = 300;
   localparam int LONG_HOLD_AT   = 120;
   localparam int LONG_HOLD_LEN  = 300;
   localparam int SETTLE_CYCLES  = 10;
   localparam int REPORT_LIMIT   = 10;

   // Op code 3 has no meaning; the block must drop it without a response.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] value;
      logic [COUNT_W-1:0]       count;
      logic                     last;
   } array_response_type;

   // Shadow copy of the array: apply each accepted request, queue the responses it
   // must cause, and match every observed response against the oldest one queued.
   class array_shadow_type;
      logic signed [DATA_W-1:0] words [ARRAY_DEPTH];
      int                       fill;
      array_response_type       pending [$];
      int                       mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      function void queue_response(logic [STATUS_W-1:0] status,
                                   logic signed [DATA_W-1:0] value, logic last);
         array_response_type rsp;
         rsp.status = status;
         rsp.value  = value;
         rsp.count  = fill[COUNT_W-1:0];
         rsp.last   = last;
         pending.push_back(rsp);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] value);
         int                       p;
         int                       i;
         logic signed [DATA_W-1:0] removed;
         p = int'(pos);
         case (op)
            OP_INSERT: begin
               // Position is checked before fullness.
               if (p == 0 || p > fill + 1) begin
                  queue_response(STATUS_BAD_POS, '0, 1'b1);
               end else if (fill >= ARRAY_DEPTH) begin
                  queue_response(STATUS_FULL, '0, 1'b1);
               end else begin
                  for (i = fill; i >= p; i--) words[i] = words[i-1];
                  words[p-1] = value;
                  fill++;
                  queue_response(STATUS_OK, '0, 1'b1);
               end
            end
            OP_DELETE: begin
               if (p == 0 || p > fill) begin
                  queue_response(STATUS_BAD_POS, '0, 1'b1);
               end else begin
                  removed = words[p-1];
                  for (i = p - 1; i + 1 < fill; i++) words[i] = words[i+1];
                  fill--;
                  queue_response(STATUS_OK, removed, 1'b1);
               end
            end
            OP_DUMP: begin
               if (fill == 0) begin
                  queue_response(STATUS_EMPTY, '0, 1'b1);
               end else begin
                  for (i = 0; i < fill; i++) queue_response(STATUS_OK, words[i], i + 1 == fill);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(array_response_type got);
         array_response_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: status=%0d value=%0d count=%0d last=%0b",
                        got.status, got.value, got.count, got.last);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status || got.value !== want.value ||
             got.count !== want.count || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response mismatch: expected status=%0d value=%0d count=%0d last=%0b",
                        want.status, want.value, want.count, want.last);
               $display("                   got      status=%0d value=%0d count=%0d last=%0b",
                        got.status, got.value, got.count, got.last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   pida_req_if req_bus ();
   pida_rsp_if rsp_bus ();

   positional_insert_delete_array #(
      .DEPTH (ARRAY_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   array_shadow_type tracker = new();

   int requests_sent     = 0;
   bit quiet_tail        = 1'b0;  // no idling on either side once set
   bit long_hold_pending = 1'b0;  // ask the response side for one long stall

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs or loses a response.
   initial begin
      #(20 * 1_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: alternate ready stretches with random stall bursts, and take the
   // one long stall on request so the command queue backs up into the request side.
   initial begin
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_LEN) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Check every response taken at a clock edge; values read here are the pre-edge ones.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         tracker.check_response({rsp_bus.status, rsp_bus.result_value,
                                 rsp_bus.entry_count, rsp_bus.last});
   end

   // Offer one request and hold it until accepted, then note it in the shadow array.
   // Valid stays high on return unless a random idle gap drops it; the next call raises it again.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] value);
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.position   <= pos;
      req_bus.item_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      tracker.note_request(op, pos, value);
      if (op != OP_UNUSED) requests_sent++;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Pick a request by weight; most positions are legal for the current fill,
   // the noise share covers stray positions and the unused op code.
   task automatic random_request(input int ins_w, input int del_w, input int dump_w,
                                 input int noise_w);
      int roll;
      int stored;
      roll   = $urandom_range(0, ins_w + del_w + dump_w + noise_w - 1);
      stored = tracker.fill;
      if (roll < ins_w) begin
         send_request(OP_INSERT, POS_W'($urandom_range(1, stored + 1)), $urandom);
      end else if (roll < ins_w + del_w) begin
         if (stored == 0) send_request(OP_DELETE, POS_W'($urandom_range(0, 2)), $urandom);
         else send_request(OP_DELETE, POS_W'($urandom_range(1, stored)), $urandom);
      end else if (roll < ins_w + del_w + dump_w) begin
         send_request(OP_DUMP, POS_W'($urandom_range(0, 63)), $urandom);
      end else if ($urandom_range(0, 4) == 0) begin
         send_request(OP_UNUSED, POS_W'($urandom_range(0, 63)), $urandom);
      end else begin
         send_request($urandom_range(0, 1) ? OP_DELETE : OP_INSERT,
                      POS_W'($urandom_range(0, 63)), $urandom);
      end
   endtask

   // Stop offering and wait until every queued response has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      bit long_hold_done;
      long_hold_done     = 1'b0;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_INSERT;
      req_bus.position   = '0;
      req_bus.item_value = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-array cases first.
      send_request(OP_DUMP,   6'd0, 32'd0);            // dump of an empty array
      send_request(OP_DELETE, 6'd1, 32'd0);            // delete from an empty array
      send_request(OP_INSERT, 6'd0, 32'd5);            // insert at position zero
      send_request(OP_INSERT, 6'd2, 32'd5);            // insert past count+1
      // Build [0, -1, min, max] with inserts at the end, the front and the middle.
      send_request(OP_INSERT, 6'd1, 32'h8000_0000);
      send_request(OP_INSERT, 6'd2, 32'h7fff_ffff);
      send_request(OP_INSERT, 6'd1, 32'h0000_0000);
      send_request(OP_INSERT, 6'd2, 32'hffff_ffff);
      send_request(OP_INSERT, 6'd63, 32'h0000_0014);   // all position bits set
      send_request(OP_UNUSED, 6'd63, 32'hffff_ffff);   // dropped without a response
      send_request(OP_DUMP,   6'd0, 32'd0);
      send_request(OP_DELETE, 6'd0, 32'd0);            // delete at position zero
      send_request(OP_DELETE, 6'd5, 32'd0);            // delete just past count
      send_request(OP_DELETE, 6'd2, 32'd0);            // middle
      send_request(OP_DELETE, 6'd3, 32'd0);            // last entry
      send_request(OP_DELETE, 6'd1, 32'd0);            // front
      send_request(OP_DUMP,   6'd63, 32'd0);           // single-entry dump
      send_request(OP_DELETE, 6'd1, 32'd0);            // back to empty
      send_request(OP_DUMP,   6'd0, 32'd0);
      send_request(OP_INSERT, 6'd1, 32'h0000_0014);

      // Random episodes: fill to full, drain to empty, or a mixed stretch.
      while (requests_sent < RANDOM_TARGET) begin
         if (requests_sent >= TAIL_START) quiet_tail = 1'b1;
         if (!long_hold_done && requests_sent >= LONG_HOLD_AT) begin
            // Pause until all responses are in, then stall the response side
            // while requests keep coming so the block backs up.
            drain_responses();
            long_hold_pending = 1'b1;
            long_hold_done    = 1'b1;
         end
         case ($urandom_range(0, 3))
            0: begin
               while (tracker.fill < ARRAY_DEPTH) random_request(90, 5, 3, 2);
               // Inserts on a full array: any position, so either error code can show.
               repeat ($urandom_range(1, 3))
                  send_request(OP_INSERT, POS_W'($urandom_range(0, 63)), $urandom);
               send_request(OP_DUMP, POS_W'($urandom_range(0, 63)), $urandom);
            end
            1: begin
               while (tracker.fill > 0) random_request(5, 85, 5, 5);
               send_request(OP_DUMP, POS_W'($urandom_range(0, 63)), $urandom);
            end
            default: begin
               repeat (20) random_request(40, 35, 10, 15);
            end
         endcase
         if ($urandom_range(0, 3) == 0) drain_responses();
      end

      drain_responses();
      if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
